### rtl/mer_pkg.sv
// ----------------------------------------------------------------------------
// mer_pkg: shared types for the midpoint ellipse rasterizer
// Holds the sequencer states, region codes and the command word of the
// shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
package mer_pkg;

    // Input operation codes.
    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    // Region of the ellipse that the next step works in.
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_R1,
        PH_R2
    } phase_t;

    // Base value that the accumulator adds its term to.
    typedef enum logic [1:0] {
        BASE_ZERO,
        BASE_ACC,
        BASE_DEC
    } base_sel_t;

    // Scaling applied to the registered product before accumulation.
    typedef enum logic [1:0] {
        SH_NONE,
        SH_LEFT1,
        SH_RIGHT2
    } shift_t;

    // Command word from the sequencer to the multiply-accumulate unit.
    typedef struct packed {
        logic      acc_en;
        base_sel_t base;
        logic      term_en;
        logic      term_neg;
        shift_t    shift;
    } mac_cmd_t;

    // Sequencer states.
    typedef enum logic [5:0] {
        ST_READY,
        ST_INIT_RX2,
        ST_INIT_RY2,
        ST_INIT_PROD,
        ST_INIT_SUB,
        ST_INIT_QUART,
        ST_INIT_ADD,
        ST_INIT_SAVE,
        ST_TEST_MUL,
        ST_TEST_LOAD,
        ST_TEST_SUB,
        ST_TEST_CHECK,
        ST_R2_XX,
        ST_R2_YY,
        ST_R2_MULX,
        ST_R2_LOAD,
        ST_R2_ADDY,
        ST_R2_SUBRR,
        ST_R2_QUART,
        ST_R2_ROUND,
        ST_R2_SAVE,
        ST_EMIT0,
        ST_EMIT1,
        ST_EMIT2,
        ST_EMIT3,
        ST_FINISH,
        ST_UPD_POS,
        ST_UPD_MULX,
        ST_UPD_ADDX,
        ST_UPD_ADDR,
        ST_UPD_SUBY,
        ST_UPD_SAVE
    } state_t;

endpackage

### rtl/mer_mac.sv
// ----------------------------------------------------------------------------
// mer_mac: shared multiply-accumulate unit
// One signed multiplier with a registered product, followed by one wide
// adder that folds the scaled product into the accumulator.
// ----------------------------------------------------------------------------
module mer_mac
    import mer_pkg::*;
#(
    parameter int AW = 19,
    parameter int BW = 21,
    parameter int DW = 42
)(
    input  logic                    clk,
    input  mac_cmd_t                cmd,
    input  logic signed [AW-1:0]    op_a,
    input  logic signed [BW-1:0]    op_b,
    input  logic signed [DW-1:0]    dec_in,
    output logic signed [AW+BW-1:0] prod,
    output logic signed [DW-1:0]    acc
);

    localparam int PW = AW + BW;

    logic signed [PW-1:0] prod_reg;
    logic signed [PW-1:0] prod_next;
    logic signed [DW-1:0] acc_reg;
    logic signed [DW-1:0] acc_next;
    logic signed [DW-1:0] prod_ext;
    logic signed [DW-1:0] term_sh;
    logic signed [DW-1:0] term;
    logic signed [DW-1:0] base_val;

    // Multiplier stage: the product is registered before it is used.
    assign prod_next = op_a * op_b;

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    // Scale and sign the registered product.
    assign prod_ext = {{(DW-PW){prod_reg[PW-1]}}, prod_reg};

    always_comb
    begin
        case (cmd.shift)
            SH_LEFT1:  term_sh = prod_ext <<< 1;
            SH_RIGHT2: term_sh = prod_ext >>> 2;
            default:   term_sh = prod_ext;
        endcase
        if (!cmd.term_en)
        begin
            term = '0;
        end
        else if (cmd.term_neg)
        begin
            term = -term_sh;
        end
        else
        begin
            term = term_sh;
        end
    end

    // Accumulator adder with a selectable base.
    always_comb
    begin
        case (cmd.base)
            BASE_ZERO: base_val = '0;
            BASE_DEC:  base_val = dec_in;
            default:   base_val = acc_reg;
        endcase
        acc_next = cmd.acc_en ? (base_val + term) : acc_reg;
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign prod = prod_reg;
    assign acc  = acc_reg;

endmodule

### rtl/midpoint_ellipse_rasterizer_core.sv
// A start transaction occupies the block and produces no result. A step in
// region 1 also runs the region test, the step that enters region 2 also builds
// the region 2 start value, and a step with no active ellipse only reports finished.
// Each point is registered in the output slot; output stall holds the sequencer in its emit states.
// The sequencing comes from the single shared multiplier, used once per cycle.
// Reset clears the sequencer, the region, the position, the decision and the output valid.
// ----------------------------------------------------------------------------
// midpoint_ellipse_rasterizer_core: midpoint ellipse rasterizer
// A start transaction loads center and radii; each step transaction emits the
// four symmetric points of the current position and advances the decision
// variable through region 1 and region 2 with a shared multiply-accumulate.
// ----------------------------------------------------------------------------
module midpoint_ellipse_rasterizer_core
    import mer_pkg::*;
#(
    parameter int COORD_BITS  = 10,
    parameter int RADIUS_BITS = 9
)(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         op,
    input  logic [COORD_BITS-1:0]        center_x,
    input  logic [COORD_BITS-1:0]        center_y,
    input  logic [RADIUS_BITS-1:0]       radius_x,
    input  logic [RADIUS_BITS-1:0]       radius_y,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [COORD_BITS+1:0] point_x,
    output logic signed [COORD_BITS+1:0] point_y,
    output logic                         last_of_step,
    output logic                         finished
);

    localparam int XW  = RADIUS_BITS + 1;
    localparam int YW  = RADIUS_BITS + 2;
    localparam int SQW = 2 * RADIUS_BITS;
    localparam int AW  = 2 * RADIUS_BITS + 1;
    localparam int BW  = 2 * RADIUS_BITS + 3;
    localparam int PW  = AW + BW;
    localparam int DW  = 4 * RADIUS_BITS + 6;
    localparam int PTW = COORD_BITS + 2;
    localparam int EW  = ((YW > PTW) ? YW : PTW) + 1;

    // Control and position state.
    state_t                  state_reg, state_next;
    phase_t                  phase_reg, phase_next;
    logic [XW-1:0]           x_reg, x_next;
    logic signed [YW-1:0]    y_reg, y_next;
    logic signed [DW-1:0]    dec_reg, dec_next;
    logic [COORD_BITS-1:0]   cx_reg, cx_next;
    logic [COORD_BITS-1:0]   cy_reg, cy_next;
    logic [RADIUS_BITS-1:0]  rx_reg, rx_next;
    logic [RADIUS_BITS-1:0]  ry_reg, ry_next;
    logic                    out_valid_reg, out_valid_next;

    // Working registers.
    logic [SQW-1:0]          rx2_reg, ry2_reg;
    logic signed [BW-1:0]    tmp_reg;
    logic                    step_x_reg, step_y_reg;
    logic [PTW-1:0]          px_reg, py_reg;
    logic                    last_reg, fin_reg;

    // Sequencer outputs.
    mac_cmd_t                cmd;
    logic signed [AW-1:0]    op_a;
    logic signed [BW-1:0]    op_b;
    logic                    ld_rx2, ld_ry2, ld_tmp_sum, ld_tmp_sq;
    logic                    ld_dec, ld_pos, ld_out;
    logic                    enter_r2, end_step;
    logic                    pt_neg_x, pt_neg_y, pt_last, pt_fin;

    // Shared unit results.
    logic signed [PW-1:0]    prod;
    logic signed [DW-1:0]    acc;

    // Miscellaneous decode.
    logic                    in_acc;
    logic                    slot_free;
    logic                    acc_neg;
    logic                    dec_neg, dec_pos;
    logic                    step_x_w, step_y_w;
    logic signed [YW-1:0]    ym1;

    // Operand views for the multiplier.
    logic signed [AW-1:0]    a_rx, a_ry, a_rx2, a_ry2, a_x, a_ym1, a_one;
    logic signed [BW-1:0]    b_rx, b_ry, b_x, b_y, b_ry2, b_one;

    // Point adders.
    logic signed [EW-1:0]    cx_e, cy_e, x_e, y_e, sum_x, sum_y;

    assign in_acc    = in_valid && !in_stall;
    assign slot_free = !out_valid_reg || !out_stall;
    assign acc_neg   = acc[DW-1];
    assign dec_neg   = dec_reg[DW-1];
    assign dec_pos   = !dec_reg[DW-1] && (dec_reg != '0);
    assign ym1       = y_reg - {{(YW-1){1'b0}}, 1'b1};

    assign a_rx  = {{(AW-RADIUS_BITS){1'b0}}, rx_reg};
    assign a_ry  = {{(AW-RADIUS_BITS){1'b0}}, ry_reg};
    assign a_rx2 = {{(AW-SQW){1'b0}}, rx2_reg};
    assign a_ry2 = {{(AW-SQW){1'b0}}, ry2_reg};
    assign a_x   = {{(AW-XW){1'b0}}, x_reg};
    assign a_ym1 = {{(AW-YW){ym1[YW-1]}}, ym1};
    assign a_one = {{(AW-1){1'b0}}, 1'b1};
    assign b_rx  = {{(BW-RADIUS_BITS){1'b0}}, rx_reg};
    assign b_ry  = {{(BW-RADIUS_BITS){1'b0}}, ry_reg};
    assign b_x   = {{(BW-XW){1'b0}}, x_reg};
    assign b_y   = {{(BW-YW){y_reg[YW-1]}}, y_reg};
    assign b_ry2 = {{(BW-SQW){1'b0}}, ry2_reg};
    assign b_one = {{(BW-1){1'b0}}, 1'b1};

    // Which coordinates move on this step, from region and decision sign.
    assign step_x_w = (phase_reg == PH_R1) || !dec_pos;
    assign step_y_w = (phase_reg == PH_R2) || !dec_neg;

    // Shared multiply-accumulate unit.
    mer_mac #(
        .AW (AW),
        .BW (BW),
        .DW (DW)
    ) u_mac (
        .clk    (clk),
        .cmd    (cmd),
        .op_a   (op_a),
        .op_b   (op_b),
        .dec_in (dec_reg),
        .prod   (prod),
        .acc    (acc)
    );

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_READY:
            begin
                if (in_acc)
                begin
                    if (op == OP_START)
                    begin
                        state_next = ST_INIT_RX2;
                    end
                    else
                    begin
                        case (phase_reg)
                            PH_IDLE: state_next = ST_FINISH;
                            PH_R1:   state_next = ST_TEST_MUL;
                            default: state_next = ST_EMIT0;
                        endcase
                    end
                end
            end
            ST_INIT_RX2:   state_next = ST_INIT_RY2;
            ST_INIT_RY2:   state_next = ST_INIT_PROD;
            ST_INIT_PROD:  state_next = ST_INIT_SUB;
            ST_INIT_SUB:   state_next = ST_INIT_QUART;
            ST_INIT_QUART: state_next = ST_INIT_ADD;
            ST_INIT_ADD:   state_next = ST_INIT_SAVE;
            ST_INIT_SAVE:  state_next = ST_READY;
            ST_TEST_MUL:   state_next = ST_TEST_LOAD;
            ST_TEST_LOAD:  state_next = ST_TEST_SUB;
            ST_TEST_SUB:   state_next = ST_TEST_CHECK;
            ST_TEST_CHECK: state_next = acc_neg ? ST_EMIT0 : ST_R2_XX;
            ST_R2_XX:      state_next = ST_R2_YY;
            ST_R2_YY:      state_next = ST_R2_MULX;
            ST_R2_MULX:    state_next = ST_R2_LOAD;
            ST_R2_LOAD:    state_next = ST_R2_ADDY;
            ST_R2_ADDY:    state_next = ST_R2_SUBRR;
            ST_R2_SUBRR:   state_next = ST_R2_QUART;
            ST_R2_QUART:   state_next = ST_R2_ROUND;
            ST_R2_ROUND:   state_next = ST_R2_SAVE;
            ST_R2_SAVE:    state_next = y_reg[YW-1] ? ST_FINISH : ST_EMIT0;
            ST_EMIT0:      state_next = slot_free ? ST_EMIT1 : ST_EMIT0;
            ST_EMIT1:      state_next = slot_free ? ST_EMIT2 : ST_EMIT1;
            ST_EMIT2:      state_next = slot_free ? ST_EMIT3 : ST_EMIT2;
            ST_EMIT3:      state_next = slot_free ? ST_UPD_POS : ST_EMIT3;
            ST_FINISH:     state_next = slot_free ? ST_READY : ST_FINISH;
            ST_UPD_POS:    state_next = ST_UPD_MULX;
            ST_UPD_MULX:   state_next = ST_UPD_ADDX;
            ST_UPD_ADDX:   state_next = ST_UPD_ADDR;
            ST_UPD_ADDR:   state_next = ST_UPD_SUBY;
            ST_UPD_SUBY:   state_next = ST_UPD_SAVE;
            ST_UPD_SAVE:   state_next = ST_READY;
            default:       state_next = ST_READY;
        endcase
    end

    // Output logic of the sequencer: multiplier operands, accumulator
    // command and register load strobes.
    always_comb
    begin
        in_stall   = (state_reg != ST_READY);
        cmd        = '{acc_en: 1'b0, base: BASE_ACC, term_en: 1'b0,
                       term_neg: 1'b0, shift: SH_NONE};
        op_a       = '0;
        op_b       = '0;
        ld_rx2     = 1'b0;
        ld_ry2     = 1'b0;
        ld_tmp_sum = 1'b0;
        ld_tmp_sq  = 1'b0;
        ld_dec     = 1'b0;
        ld_pos     = 1'b0;
        ld_out     = 1'b0;
        enter_r2   = 1'b0;
        end_step   = 1'b0;
        pt_neg_x   = 1'b0;
        pt_neg_y   = 1'b0;
        pt_last    = 1'b0;
        pt_fin     = 1'b0;
        case (state_reg)
            // Start: d = ry^2 - rx^2*ry + floor(rx^2/4).
            ST_INIT_RX2:
            begin
                op_a = a_rx;
                op_b = b_rx;
            end
            ST_INIT_RY2:
            begin
                ld_rx2 = 1'b1;
                op_a   = a_ry;
                op_b   = b_ry;
            end
            ST_INIT_PROD:
            begin
                ld_ry2 = 1'b1;
                op_a   = a_rx2;
                op_b   = b_ry;
            end
            ST_INIT_SUB:
            begin
                cmd  = '{acc_en: 1'b1, base: BASE_ZERO, term_en: 1'b1,
                         term_neg: 1'b1, shift: SH_NONE};
                op_a = a_rx2;
                op_b = b_one;
            end
            ST_INIT_QUART:
            begin
                cmd  = '{acc_en: 1'b1, base: BASE_ACC, term_en: 1'b1,
                         term_neg: 1'b0, shift: SH_RIGHT2};
                op_a = a_ry2;
                op_b = b_one;
            end
            ST_INIT_ADD:
            begin
                cmd = '{acc_en: 1'b1, base: BASE_ACC, term_en: 1'b1,
                        term_neg: 1'b0, shift: SH_NONE};
            end
            ST_INIT_SAVE:
            begin
                ld_dec = 1'b1;
            end
            // Region 1 test: x*ry^2 - y*rx^2 < 0.
            ST_TEST_MUL:
            begin
                op_a = a_ry2;
                op_b = b_x;
            end
            ST_TEST_LOAD:
            begin
                cmd  = '{acc_en: 1'b1, base: BASE_ZERO, term_en: 1'b1,
                         term_neg: 1'b0, shift: SH_NONE};
                op_a = a_rx2;
                op_b = b_y;
            end
            ST_TEST_SUB:
            begin
                cmd = '{acc_en: 1'b1, base: BASE_ACC, term_en: 1'b1,
                        term_neg: 1'b1, shift: SH_NONE};
            end
            // Region 2 start, in quarter units, truncated toward zero.
            ST_R2_XX:
            begin
                op_a = a_x;
                op_b = b_x;
            end
            ST_R2_YY:
            begin
                ld_tmp_sum = 1'b1;
                op_a       = a_ym1;
                op_b       = {{(BW-AW){a_ym1[AW-1]}}, a_ym1};
            end
            ST_R2_MULX:
            begin
                ld_tmp_sq = 1'b1;
                op_a      = a_ry2;
                op_b      = tmp_reg;
            end
            ST_R2_LOAD:
            begin
                cmd  = '{acc_en: 1'b1, base: BASE_ZERO, term_en: 1'b1,
                         term_neg: 1'b0, shift: SH_NONE};
                op_a = a_rx2;
                op_b = tmp_reg;
            end
            ST_R2_ADDY:
            begin
                cmd  = '{acc_en: 1'b1, base: BASE_ACC, term_en: 1'b1,
                         term_neg: 1'b0, shift: SH_NONE};
                op_a = a_rx2;
                op_b = b_ry2;
            end
            ST_R2_SUBRR:
            begin
                cmd  = '{acc_en: 1'b1, base: BASE_ACC, term_en: 1'b1,
                         term_neg: 1'b1, shift: SH_NONE};
                op_a = a_ry2;
                op_b = b_one;
            end
            ST_R2_QUART:
            begin
                cmd  = '{acc_en: 1'b1, base: BASE_ACC, term_en: 1'b1,
                         term_neg: 1'b0, shift: SH_RIGHT2};
                op_a = a_one;
                op_b = b_one;
            end
            ST_R2_ROUND:
            begin
                // A negative value with a dropped quarter moves up by one.
                cmd = '{acc_en: acc_neg && (ry2_reg[1:0] != 2'b00), base: BASE_ACC,
                        term_en: 1'b1, term_neg: 1'b0, shift: SH_NONE};
            end
            ST_R2_SAVE:
            begin
                ld_dec   = 1'b1;
                enter_r2 = 1'b1;
            end
            // Four symmetric points, one per transaction.
            ST_EMIT0:
            begin
                ld_out   = slot_free;
                pt_neg_y = 1'b1;
            end
            ST_EMIT1:
            begin
                ld_out   = slot_free;
                pt_neg_x = 1'b1;
            end
            ST_EMIT2:
            begin
                ld_out = slot_free;
            end
            ST_EMIT3:
            begin
                ld_out   = slot_free;
                pt_neg_x = 1'b1;
                pt_neg_y = 1'b1;
                pt_last  = 1'b1;
            end
            ST_FINISH:
            begin
                ld_out  = slot_free;
                pt_last = 1'b1;
                pt_fin  = 1'b1;
            end
            // Decision update with the new position.
            ST_UPD_POS:
            begin
                ld_pos = 1'b1;
            end
            ST_UPD_MULX:
            begin
                op_a = a_ry2;
                op_b = b_x;
            end
            ST_UPD_ADDX:
            begin
                cmd  = '{acc_en: 1'b1, base: BASE_DEC, term_en: step_x_reg,
                         term_neg: 1'b0, shift: SH_LEFT1};
                op_a = (phase_reg == PH_R1) ? a_ry2 : a_rx2;
                op_b = b_one;
            end
            ST_UPD_ADDR:
            begin
                cmd  = '{acc_en: 1'b1, base: BASE_ACC, term_en: 1'b1,
                         term_neg: 1'b0, shift: SH_NONE};
                op_a = a_rx2;
                op_b = b_y;
            end
            ST_UPD_SUBY:
            begin
                cmd = '{acc_en: 1'b1, base: BASE_ACC, term_en: step_y_reg,
                        term_neg: 1'b1, shift: SH_LEFT1};
            end
            ST_UPD_SAVE:
            begin
                ld_dec   = 1'b1;
                end_step = 1'b1;
            end
            default:
            begin
                cmd = '{acc_en: 1'b0, base: BASE_ACC, term_en: 1'b0,
                        term_neg: 1'b0, shift: SH_NONE};
            end
        endcase
    end

    // Next values of the control and position state.
    always_comb
    begin
        phase_next = phase_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        dec_next   = ld_dec ? acc : dec_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        rx_next    = rx_reg;
        ry_next    = ry_reg;
        if (in_acc && (op == OP_START))
        begin
            cx_next    = center_x;
            cy_next    = center_y;
            rx_next    = radius_x;
            ry_next    = radius_y;
            x_next     = '0;
            y_next     = {2'b00, radius_y};
            phase_next = PH_R1;
        end
        if (ld_pos)
        begin
            x_next = x_reg + {{(XW-1){1'b0}}, step_x_w};
            y_next = y_reg - {{(YW-1){1'b0}}, step_y_w};
        end
        if (enter_r2)
        begin
            phase_next = y_reg[YW-1] ? PH_IDLE : PH_R2;
        end
        if (end_step && (phase_reg == PH_R2) && y_reg[YW-1])
        begin
            phase_next = PH_IDLE;
        end
    end

    // Output slot: loads when empty or when its transaction completes.
    assign out_valid_next = ld_out || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_READY;
            phase_reg     <= PH_IDLE;
            x_reg         <= '0;
            y_reg         <= '0;
            dec_reg       <= '0;
            cx_reg        <= '0;
            cy_reg        <= '0;
            rx_reg        <= '0;
            ry_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            x_reg         <= x_next;
            y_reg         <= y_next;
            dec_reg       <= dec_next;
            cx_reg        <= cx_next;
            cy_reg        <= cy_next;
            rx_reg        <= rx_next;
            ry_reg        <= ry_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Point adders: center plus or minus the current offset.
    assign cx_e  = {{(EW-COORD_BITS){1'b0}}, cx_reg};
    assign cy_e  = {{(EW-COORD_BITS){1'b0}}, cy_reg};
    assign x_e   = {{(EW-XW){1'b0}}, x_reg};
    assign y_e   = {{(EW-YW){y_reg[YW-1]}}, y_reg};
    assign sum_x = pt_neg_x ? (cx_e - x_e) : (cx_e + x_e);
    assign sum_y = pt_neg_y ? (cy_e - y_e) : (cy_e + y_e);

    // Working registers without reset.
    always_ff @(posedge clk)
    begin
        if (ld_rx2)
        begin
            rx2_reg <= prod[SQW-1:0];
        end
        if (ld_ry2)
        begin
            ry2_reg <= prod[SQW-1:0];
        end
        if (ld_tmp_sum)
        begin
            tmp_reg <= prod[BW-1:0] + b_x;
        end
        else if (ld_tmp_sq)
        begin
            tmp_reg <= prod[BW-1:0];
        end
        if (ld_pos)
        begin
            step_x_reg <= step_x_w;
            step_y_reg <= step_y_w;
        end
        if (ld_out)
        begin
            px_reg   <= pt_fin ? '0 : sum_x[PTW-1:0];
            py_reg   <= pt_fin ? '0 : sum_y[PTW-1:0];
            last_reg <= pt_last;
            fin_reg  <= pt_fin;
        end
    end

    assign out_valid    = out_valid_reg;
    assign point_x      = px_reg;
    assign point_y      = py_reg;
    assign last_of_step = last_reg;
    assign finished     = fin_reg;

    // Region 2 is never left waiting with a negative row.
    a_r2_row_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_READY) && (phase_reg == PH_R2)) |-> !y_reg[YW-1])
        else $error("region 2 idle with negative row");

    // A step with no active ellipse goes straight to the finished result.
    a_idle_step: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && (op == OP_STEP) && (phase_reg == PH_IDLE))
        |=> (state_reg == ST_FINISH))
        else $error("idle step did not report finished");

    // A finished result is the last of its step and carries no point.
    a_finished_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && finished) |-> (last_of_step && (point_x == '0) && (point_y == '0)))
        else $error("malformed finished result");

    // A start places the block at the top of the ellipse in region 1.
    a_start_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && (op == OP_START))
        |=> ((phase_reg == PH_R1) && (x_reg == '0)))
        else $error("start did not enter region 1 at column zero");

endmodule

### test/ellipse_point_checker.sv
// ----------------------------------------------------------------------------
// ellipse_point_checker: result checker for the midpoint ellipse rasterizer
// Watches the input and output channels of the core. It keeps its own copy of
// the rasterizer state, predicts the points that every accepted step
// transaction must produce, and compares each accepted result field by field.
// ----------------------------------------------------------------------------
module ellipse_point_checker
    import mer_pkg::*;
#(
    parameter int COORD_BITS  = 10,
    parameter int RADIUS_BITS = 9
)(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_stall,
    input  logic                         op,
    input  logic [COORD_BITS-1:0]        center_x,
    input  logic [COORD_BITS-1:0]        center_y,
    input  logic [RADIUS_BITS-1:0]       radius_x,
    input  logic [RADIUS_BITS-1:0]       radius_y,
    input  logic                         out_valid,
    input  logic                         out_stall,
    input  logic signed [COORD_BITS+1:0] point_x,
    input  logic signed [COORD_BITS+1:0] point_y,
    input  logic                         last_of_step,
    input  logic                         finished,
    output int                           pending,
    output int                           mismatches,
    output int                           results_checked,
    output int                           idle_reports
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PW = COORD_BITS + 2;

    // One predicted result of a step transaction.
    typedef struct packed {
        logic [PW-1:0] px;
        logic [PW-1:0] py;
        logic          last;
        logic          fin;
    } plot_point_t;

    plot_point_t expected_points[$];

    // Predicted rasterizer state.
    phase_t                 region;
    longint                 pos_x;
    longint                 pos_y;
    longint                 dec;
    logic [COORD_BITS-1:0]  ctr_x;
    logic [COORD_BITS-1:0]  ctr_y;
    logic [RADIUS_BITS-1:0] rad_x;
    logic [RADIUS_BITS-1:0] rad_y;

    int err_total;
    int seen_total;
    int idle_total;

    // Queue one point; coordinates wrap to the output width.
    function automatic void push_point(longint px, longint py, logic last);
        plot_point_t p;
        p.px   = px[PW-1:0];
        p.py   = py[PW-1:0];
        p.last = last;
        p.fin  = 1'b0;
        expected_points.push_back(p);
    endfunction

    // A start transaction loads the ellipse and sets up region 1.
    function automatic void load_ellipse();
        longint rx2;
        longint ry2;
        rx2    = longint'(radius_x) * longint'(radius_x);
        ry2    = longint'(radius_y) * longint'(radius_y);
        ctr_x  = center_x;
        ctr_y  = center_y;
        rad_x  = radius_x;
        rad_y  = radius_y;
        pos_x  = 0;
        pos_y  = longint'(radius_y);
        dec    = ry2 - rx2 * longint'(radius_y) + rx2 / 4;
        region = PH_R1;
    endfunction

    // A step emits four points, or an idle report, and moves the decision on.
    function automatic void advance_ellipse();
        longint      rx2;
        longint      ry2;
        longint      ym1;
        longint      whole;
        longint      cx;
        longint      cy;
        plot_point_t idle_pt;
        rx2 = longint'(rad_x) * longint'(rad_x);
        ry2 = longint'(rad_y) * longint'(rad_y);
        cx  = longint'(ctr_x);
        cy  = longint'(ctr_y);

        // Leaving region 1: the start value is built in quarter units and
        // truncated toward zero.
        if (region == PH_R1 && !(2 * pos_x * ry2 < 2 * pos_y * rx2))
        begin
            ym1   = pos_y - 1;
            whole = ry2 * (pos_x * pos_x + pos_x) + rx2 * ym1 * ym1 - rx2 * ry2 + ry2 / 4;
            if (whole < 0 && ry2 % 4 != 0)
                whole = whole + 1;
            dec    = whole;
            region = PH_R2;
        end
        if (region == PH_R2 && pos_y < 0)
            region = PH_IDLE;

        if (region == PH_IDLE)
        begin
            // No active ellipse: a single report with no point.
            idle_pt.px   = '0;
            idle_pt.py   = '0;
            idle_pt.last = 1'b1;
            idle_pt.fin  = 1'b1;
            expected_points.push_back(idle_pt);
        end
        else
        begin
            push_point(cx + pos_x, cy - pos_y, 1'b0);
            push_point(cx - pos_x, cy + pos_y, 1'b0);
            push_point(cx + pos_x, cy + pos_y, 1'b0);
            push_point(cx - pos_x, cy - pos_y, 1'b1);

            if (region == PH_R1)
            begin
                pos_x = pos_x + 1;
                if (dec < 0)
                begin
                    dec = dec + 2 * ry2 * pos_x + ry2;
                end
                else
                begin
                    pos_y = pos_y - 1;
                    dec   = dec + 2 * ry2 * pos_x + ry2 - 2 * rx2 * pos_y;
                end
            end
            else
            begin
                pos_y = pos_y - 1;
                if (dec > 0)
                begin
                    dec = dec + rx2 - 2 * rx2 * pos_y;
                end
                else
                begin
                    pos_x = pos_x + 1;
                    dec   = dec + 2 * ry2 * pos_x - 2 * rx2 * pos_y + rx2;
                end
                if (pos_y < 0)
                    region = PH_IDLE;
            end
        end
    endfunction

    // Compare one field and report a difference.
    function automatic bit field_matches(string field, logic signed [PW-1:0] want,
                                         logic signed [PW-1:0] got);
        if (got === want)
            return 1'b1;
        $display("[%0t] %s mismatch: expected %0d, got %0d", $time, field, want, got);
        return 1'b0;
    endfunction

    // Check accepted results, then predict from accepted input transactions.
    always @(posedge clk or negedge rst_n)
    begin
        plot_point_t want;
        if (!rst_n)
        begin
            expected_points.delete();
            region     = PH_IDLE;
            pos_x      = 0;
            pos_y      = 0;
            dec        = 0;
            ctr_x      = '0;
            ctr_y      = '0;
            rad_x      = '0;
            rad_y      = '0;
            err_total  = 0;
            seen_total = 0;
            idle_total = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_points.size() == 0)
                begin
                    $display("[%0t] unexpected result: expected none, got (%0d, %0d)",
                             $time, point_x, point_y);
                    $display("[%0t]   with last %b fin %b", $time, last_of_step, finished);
                    err_total = err_total + 1;
                end
                else
                begin
                    want       = expected_points.pop_front();
                    seen_total = seen_total + 1;
                    if (want.fin)
                        idle_total = idle_total + 1;
                    if (!field_matches("point_x", want.px, point_x))
                        err_total = err_total + 1;
                    if (!field_matches("point_y", want.py, point_y))
                        err_total = err_total + 1;
                    if (!field_matches("last_of_step", want.last, last_of_step))
                        err_total = err_total + 1;
                    if (!field_matches("finished", want.fin, finished))
                        err_total = err_total + 1;
                end
            end
            if (in_valid && !in_stall)
            begin
                if (op == OP_START)
                    load_ellipse();
                else
                    advance_ellipse();
            end
        end
        pending         <= expected_points.size();
        mismatches      <= err_total;
        results_checked <= seen_total;
        idle_reports    <= idle_total;
    end

endmodule

### test/midpoint_ellipse_rasterizer_core_tb.sv
// ----------------------------------------------------------------------------
// midpoint_ellipse_rasterizer_core_tb: regression for the ellipse rasterizer
// Drives directed and random start/step transactions under three mixes of
// sender gaps and receiver stalls, including a long output hold, while a
// separate checker predicts and compares every emitted point.
// ----------------------------------------------------------------------------
module midpoint_ellipse_rasterizer_core_tb
    import mer_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_BITS    = 10;
    localparam int RADIUS_BITS   = 9;
    localparam int RANDOM_ITEMS  = 120;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 200000;

    logic                         clk;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_stall;
    logic                         op;
    logic [COORD_BITS-1:0]        center_x;
    logic [COORD_BITS-1:0]        center_y;
    logic [RADIUS_BITS-1:0]       radius_x;
    logic [RADIUS_BITS-1:0]       radius_y;
    logic                         out_valid;
    logic                         out_stall;
    logic signed [COORD_BITS+1:0] point_x;
    logic signed [COORD_BITS+1:0] point_y;
    logic                         last_of_step;
    logic                         finished;

    int pending;
    int mismatches;
    int results_checked;
    int idle_reports;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_armed     = 1'b0;
    bit hold_used      = 1'b0;
    int hold_left      = 0;
    int cycle_count    = 0;
    int n_starts       = 0;
    int n_steps        = 0;

    midpoint_ellipse_rasterizer_core #(
        .COORD_BITS  (COORD_BITS),
        .RADIUS_BITS (RADIUS_BITS)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .op           (op),
        .center_x     (center_x),
        .center_y     (center_y),
        .radius_x     (radius_x),
        .radius_y     (radius_y),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .point_x      (point_x),
        .point_y      (point_y),
        .last_of_step (last_of_step),
        .finished     (finished)
    );

    ellipse_point_checker #(
        .COORD_BITS  (COORD_BITS),
        .RADIUS_BITS (RADIUS_BITS)
    ) point_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .op              (op),
        .center_x        (center_x),
        .center_y        (center_y),
        .radius_x        (radius_x),
        .radius_y        (radius_y),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .point_x         (point_x),
        .point_y         (point_y),
        .last_of_step    (last_of_step),
        .finished        (finished),
        .pending         (pending),
        .mismatches      (mismatches),
        .results_checked (results_checked),
        .idle_reports    (idle_reports)
    );

    // 50 MHz clock.
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Receiver: one long hold when armed, otherwise random stalls.
    always @(posedge clk)
    begin
        if (hold_armed && !hold_used)
        begin
            hold_used <= 1'b1;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[%0t] timeout after %0d cycles, %0d results outstanding",
                     $time, cycle_count, pending);
            $display("midpoint_ellipse_rasterizer_core regression: fail");
            $finish;
        end
    end

    // Offer one transaction after random gaps and hold it until accepted.
    task automatic send_item(input logic kind, input logic [COORD_BITS-1:0] cx,
                             input logic [COORD_BITS-1:0] cy,
                             input logic [RADIUS_BITS-1:0] rx,
                             input logic [RADIUS_BITS-1:0] ry);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        op       <= kind;
        center_x <= cx;
        center_y <= cy;
        radius_x <= rx;
        radius_y <= ry;
        do
            @(posedge clk);
        while (in_stall);
        if (kind == OP_START)
            n_starts++;
        else
            n_steps++;
    endtask

    // Step transactions carry random values in the unused fields.
    task automatic send_step();
        send_item(OP_STEP, COORD_BITS'($urandom_range(0, 1023)),
                  COORD_BITS'($urandom_range(0, 1023)),
                  RADIUS_BITS'($urandom_range(0, 511)),
                  RADIUS_BITS'($urandom_range(0, 511)));
    endtask

    // Stop offering until every predicted result has come out.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Stimulus and verdict.
    initial
    begin
        int rx;
        int ry;
        int steps;
        int full_run;
        int kind;
        int mode;
        int rand_items;

        rst_n     = 1'b0;
        in_valid  = 1'b0;
        op        = OP_STEP;
        center_x  = '0;
        center_y  = '0;
        radius_x  = '0;
        radius_y  = '0;
        out_stall = 1'b0;
        repeat (4) @(posedge clk);
        rst_n          <= 1'b1;
        send_idle_pct   = 10;
        recv_stall_pct <= 77;
        @(posedge clk);

        // Directed: a step with nothing active right out of reset.
        send_item(OP_STEP, 10'h3FF, 10'h3FF, 9'h1FF, 9'h1FF);
        // Zero radii: four copies of the center, then idle reports.
        send_item(OP_START, 10'd500, 10'd600, 9'd0, 9'd0);
        repeat (3) send_step();
        // Largest radii at the origin: points go negative.
        send_item(OP_START, 10'd0, 10'd0, 9'd511, 9'd511);
        repeat (2) send_step();
        // A start while the previous ellipse is still active abandons it.
        send_item(OP_START, 10'h3FF, 10'h3FF, 9'd511, 9'd0);
        repeat (2) send_step();
        send_item(OP_START, 10'h3FF, 10'd0, 9'd0, 9'd511);
        repeat (2) send_step();
        // A small ellipse run to completion and past it.
        send_item(OP_START, 10'd300, 10'd200, 9'd3, 9'd2);
        repeat (8) send_step();
        wait_drained();

        // Random: mostly whole small ellipses, some large ones cut short,
        // some lone steps.
        mode       = 0;
        rand_items = 0;
        while (rand_items < RANDOM_ITEMS)
        begin
            if (mode == 0 && rand_items >= RANDOM_ITEMS / 3)
            begin
                wait_drained();
                mode            = 1;
                send_idle_pct   = 77;
                recv_stall_pct <= 10;
                hold_armed     <= 1'b1;
            end
            else if (mode == 1 && rand_items >= 2 * RANDOM_ITEMS / 3)
            begin
                wait_drained();
                mode            = 2;
                send_idle_pct   = 0;
                recv_stall_pct <= 0;
            end

            kind = $urandom_range(0, 99);
            if (kind < 8)
            begin
                steps = $urandom_range(1, 3);
            end
            else
            begin
                if (kind < 78)
                begin
                    rx       = $urandom_range(0, 7);
                    ry       = $urandom_range(0, 7);
                    full_run = rx + ry + 3;
                    steps    = ($urandom_range(0, 3) == 0) ? $urandom_range(0, full_run)
                                                          : full_run;
                end
                else
                begin
                    rx    = $urandom_range(0, 511);
                    ry    = $urandom_range(0, 511);
                    steps = $urandom_range(0, 5);
                end
                send_item(OP_START, COORD_BITS'($urandom_range(0, 1023)),
                          COORD_BITS'($urandom_range(0, 1023)),
                          RADIUS_BITS'(rx), RADIUS_BITS'(ry));
                rand_items++;
            end
            repeat (steps)
            begin
                send_step();
                rand_items++;
            end
        end

        // Drain and let any stray result show up.
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d starts and %0d steps under three gap/stall mixes",
                 n_starts, n_steps);
        $display("and a %0d-cycle hold; compared %0d results, %0d of them idle reports.",
                 HOLD_CYCLES, results_checked, idle_reports);
        if (mismatches == 0)
            $display("midpoint_ellipse_rasterizer_core regression: pass");
        else
            $display("midpoint_ellipse_rasterizer_core regression: fail");
        $finish;
    end

endmodule
